// ===== sv/mbla_pkg.sv =====
`default_nettype none
package mbla_pkg;

    localparam int unsigned POOL_CELLS = 1024;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned OFF_W      = $clog2(WORD_W);
    localparam int unsigned CELL_W     = $clog2(POOL_CELLS);
    localparam int unsigned WORDS      = POOL_CELLS / WORD_W;
    localparam int unsigned WIDX_W     = CELL_W - OFF_W;
    localparam int unsigned CNT_W      = 11;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [OFF_W-1:0]  t_off;
    typedef logic [WIDX_W-1:0] t_widx;
    typedef logic [CELL_W-1:0] t_cell;

    typedef enum logic [1:0] {
        ST_ALLOC     = 2'd0,
        ST_NEED_MARK = 2'd1,
        ST_FULL      = 2'd2,
        ST_MARKED    = 2'd3
    } t_status;

    typedef enum logic {
        CMD_MARK  = 1'b0,
        CMD_ALLOC = 1'b1
    } t_cmd;

    // one read and one write port on the mark-bit store
    typedef struct packed {
        logic  rd_en;
        t_widx rd_addr;
        logic  wr_en;
        t_widx wr_addr;
        t_word wr_data;
    } t_mem_req;

endpackage
`default_nettype wire

// ===== sv/mark_bit_lazy_sweep_allocator_unit.sv =====
`default_nettype none
// Mark: the word is read as the input is taken; the result is registered once the output is free.
// Alloc: the sweep reads the mark words it scans (1 to 32), one 32-bit word per cycle
// through the single read port of the mark memory, and registers the result once the output is free.
// One item at a time: the next input transfer is taken once a result is presented.
// Reset: synchronous, active low; per-row valid bits clear all marks at once,
// so no clearing pass; cell_count returns to 1024.
module mark_bit_lazy_sweep_allocator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input items
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_command,
    input  wire logic [mbla_pkg::CELL_W-1:0]   i_mark_id,
    // results
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [1:0]                         o_status,
    output logic [mbla_pkg::CELL_W-1:0]        o_cell_id,
    output logic [mbla_pkg::CNT_W-1:0]         o_marked_count,
    output logic                               o_grow_hint,
    // cell_count register
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mbla_pkg::CNT_W-1:0]    i_cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    // grow threshold: 1 for tiny pools, else three quarters of the cells
    function automatic mbla_pkg::t_cnt grow_level(input mbla_pkg::t_cnt n);
        grow_level = (n < mbla_pkg::t_cnt'(4)) ? mbla_pkg::t_cnt'(1) : n - (n >> 2);
    endfunction

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    t_state               r_state,    n_state;
    logic                 r_cmd,      n_cmd;
    mbla_pkg::t_cell      r_mark_id,  n_mark_id;
    logic                 r_in_range, n_in_range;
    logic                 r_empty,    n_empty;
    mbla_pkg::t_widx      r_widx,     n_widx;
    mbla_pkg::t_off       r_off,      n_off;
    mbla_pkg::t_cnt       r_ptr,      n_ptr;
    mbla_pkg::t_cnt       r_total,    n_total;
    logic                 r_after,    n_after;
    mbla_pkg::t_cnt       r_live,     n_live;
    mbla_pkg::t_cnt       r_thresh,   n_thresh;
    logic                 r_ovalid,   n_ovalid;
    mbla_pkg::t_status    r_status,   n_status;
    mbla_pkg::t_cell      r_cell,     n_cell;
    mbla_pkg::t_cnt       r_count,    n_count;
    logic                 r_hint,     n_hint;

    // ---------------------------------------------------------------
    // mark memory
    // ---------------------------------------------------------------
    mbla_pkg::t_mem_req   mem_req;
    mbla_pkg::t_word      rd_word;

    mbla_mark_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_word)
    );

    // ---------------------------------------------------------------
    // word evaluation
    // ---------------------------------------------------------------
    mbla_pkg::t_cnt  base;       // first cell of the word in hand
    mbla_pkg::t_cnt  rem;        // cells left in the pool from base
    logic            lim_all;    // whole word lies inside the pool
    logic            last_word;  // no cells beyond this word
    mbla_pkg::t_word lim_mask;
    mbla_pkg::t_word low_mask;
    mbla_pkg::t_word in_mask;    // bits the sweep looks at in this word
    mbla_pkg::t_word masked;
    mbla_pkg::t_word zero_hot;   // first free cell, one-hot
    mbla_pkg::t_word pass_mask;  // marks swept over, to clear
    logic            found;
    mbla_pkg::t_off  hit_off;
    mbla_pkg::t_word bit_hot;
    logic            fresh;      // mark hits an unmarked in-range cell
    mbla_pkg::t_cnt  total_inc;
    logic            out_free;
    logic            in_xfer;

    assign base      = mbla_pkg::t_cnt'({r_widx, {mbla_pkg::OFF_W{1'b0}}});
    assign rem       = r_live - base;
    assign lim_all   = rem >= mbla_pkg::t_cnt'(mbla_pkg::WORD_W);
    assign last_word = rem <= mbla_pkg::t_cnt'(mbla_pkg::WORD_W);
    assign lim_mask  = lim_all ? '1
                     : (mbla_pkg::t_word'(1) << rem[mbla_pkg::OFF_W-1:0])
                       - mbla_pkg::t_word'(1);
    assign low_mask  = (mbla_pkg::t_word'(1) << r_off) - mbla_pkg::t_word'(1);
    assign in_mask   = lim_mask & ~low_mask;
    // cells outside the window count as marked, so the lowest zero is the hit
    assign masked    = rd_word | ~in_mask;
    assign zero_hot  = ~masked & (masked + mbla_pkg::t_word'(1));
    assign found     = |zero_hot;
    assign pass_mask = found ? (in_mask & (zero_hot - mbla_pkg::t_word'(1))) : in_mask;

    always_comb begin
        hit_off = '0;
        for (int i = 0; i < mbla_pkg::WORD_W; i++) begin
            if (zero_hot[i]) begin
                hit_off = hit_off | mbla_pkg::t_off'(i);
            end
        end
    end

    assign bit_hot   = mbla_pkg::t_word'(1) << r_mark_id[mbla_pkg::OFF_W-1:0];
    assign fresh     = r_in_range && ((rd_word & bit_hot) == '0);
    assign total_inc = (r_total == '1) ? r_total : r_total + mbla_pkg::t_cnt'(1);

    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_mark_id  = r_mark_id;
        n_in_range = r_in_range;
        n_empty    = r_empty;
        n_widx     = r_widx;
        n_off      = r_off;
        n_ptr      = r_ptr;
        n_total    = r_total;
        n_after    = r_after;
        n_live     = r_live;
        n_thresh   = r_thresh;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_status   = r_status;
        n_cell     = r_cell;
        n_count    = r_count;
        n_hint     = r_hint;

        mem_req         = '0;
        mem_req.wr_addr = r_widx;

        if (i_cfg_valid) begin
            n_live   = (i_cfg_data > mbla_pkg::t_cnt'(mbla_pkg::POOL_CELLS))
                     ? mbla_pkg::t_cnt'(mbla_pkg::POOL_CELLS) : i_cfg_data;
            n_thresh = grow_level(n_live);
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd      = i_command;
                    n_mark_id  = i_mark_id;
                    n_in_range = mbla_pkg::t_cnt'(i_mark_id) < r_live;
                    n_empty    = r_ptr >= r_live;
                    n_widx     = (i_command == mbla_pkg::CMD_ALLOC)
                               ? r_ptr[mbla_pkg::CELL_W-1:mbla_pkg::OFF_W]
                               : i_mark_id[mbla_pkg::CELL_W-1:mbla_pkg::OFF_W];
                    n_off      = r_ptr[mbla_pkg::OFF_W-1:0];
                    n_state    = S_EVAL;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = n_widx;
                end
            end
            S_EVAL: begin
                if (r_cmd == mbla_pkg::CMD_MARK) begin
                    if (out_free) begin
                        mem_req.wr_en   = fresh;
                        mem_req.wr_data = rd_word | bit_hot;
                        n_total  = fresh ? total_inc : r_total;
                        n_status = mbla_pkg::ST_MARKED;
                        n_cell   = '0;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (!r_empty && !found && !last_word) begin
                    // sweep on through the next word; no result yet
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = rd_word & ~pass_mask;
                    n_widx          = r_widx + mbla_pkg::t_widx'(1);
                    n_off           = '0;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = n_widx;
                end else if (out_free) begin
                    mem_req.wr_en   = !r_empty;
                    mem_req.wr_data = rd_word & ~pass_mask;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                    if (!r_empty && found) begin
                        n_status = mbla_pkg::ST_ALLOC;
                        n_cell   = {r_widx, hit_off};
                        n_ptr    = mbla_pkg::t_cnt'({r_widx, hit_off}) + mbla_pkg::t_cnt'(1);
                        n_after  = 1'b0;
                    end else if (!r_after) begin
                        // sweep ran dry: ask for a mark phase
                        n_status = mbla_pkg::ST_NEED_MARK;
                        n_cell   = '0;
                        n_total  = '0;
                        n_ptr    = '0;
                        n_after  = 1'b1;
                    end else begin
                        // dry again straight after a mark phase
                        n_status = mbla_pkg::ST_FULL;
                        n_cell   = '0;
                        n_after  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_count = n_total;
        n_hint  = n_ovalid && !(r_ovalid && !i_out_ready) ? (n_total >= n_thresh) : r_hint;
        if (r_ovalid && !i_out_ready) begin
            n_count = r_count;
        end else if (!(r_state == S_EVAL && n_state == S_IDLE)) begin
            n_count = r_count;
        end
        if (r_state == S_EVAL && n_state == S_IDLE) begin
            n_hint = n_total >= r_thresh;
        end else begin
            n_hint = r_hint;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_total  <= '0;
            r_after  <= 1'b0;
            r_live   <= mbla_pkg::t_cnt'(mbla_pkg::POOL_CELLS);
            r_thresh <= grow_level(mbla_pkg::t_cnt'(mbla_pkg::POOL_CELLS));
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_total  <= n_total;
            r_after  <= n_after;
            r_live   <= n_live;
            r_thresh <= n_thresh;
            r_ovalid <= n_ovalid;
        end
        r_cmd      <= n_cmd;
        r_mark_id  <= n_mark_id;
        r_in_range <= n_in_range;
        r_empty    <= n_empty;
        r_widx     <= n_widx;
        r_off      <= n_off;
        r_status   <= n_status;
        r_cell     <= n_cell;
        r_count    <= n_count;
        r_hint     <= n_hint;
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_status;
    assign o_cell_id      = r_cell;
    assign o_marked_count = r_count;
    assign o_grow_hint    = r_hint;

endmodule
`default_nettype wire

// ===== sv/mbla_mark_store.sv =====
`default_nettype none
module mbla_mark_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mbla_pkg::t_mem_req i_req,
    output mbla_pkg::t_word        o_rd_data
);

    mbla_pkg::t_word                r_mem [mbla_pkg::WORDS];
    logic [mbla_pkg::WORDS-1:0]     r_row_vld;
    mbla_pkg::t_word                r_q;
    logic                           r_q_vld;

    // rows never written read as all clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_req.wr_en) begin
            r_row_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_q     <= r_mem[i_req.rd_addr];
            r_q_vld <= r_row_vld[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule
`default_nettype wire

// ===== sv/mbla_port_checker.sv =====
`default_nettype none
module mbla_port_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [1:0]                    o_status,
    input wire logic [mbla_pkg::CELL_W-1:0]   o_cell_id,
    input wire logic [mbla_pkg::CNT_W-1:0]    o_marked_count,
    input wire logic                          o_grow_hint
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_cell_id) && $stable(o_marked_count) && $stable(o_grow_hint))
        else $error("result changed while stalled");

    // one item in flight: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one in flight");

    // cell id only carries a value on an allocation
    a_cell_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != mbla_pkg::ST_ALLOC) |-> o_cell_id == '0)
        else $error("cell id set on a non-allocation result");

    // mark phase request restarts the count
    a_need_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == mbla_pkg::ST_NEED_MARK)
            |-> o_marked_count == '0 && !o_grow_hint)
        else $error("mark phase request with a live count");

    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result presented after reset");

endmodule

bind mark_bit_lazy_sweep_allocator_unit mbla_port_checker u_port_checker (.*);
`default_nettype wire

// ===== tb/tb_mark_bit_lazy_sweep_allocator_unit.sv =====
`default_nettype none

typedef struct {
    mbla_pkg::t_status status;
    mbla_pkg::t_cell   cell_id;
    mbla_pkg::t_cnt    count;
    logic              hint;
} t_alloc_reply;

// Keeps its own copy of the mark bits, sweep pointer, count and phase flag;
// each accepted command is turned into the reply it must produce.
class alloc_scoreboard;
    localparam int unsigned COUNT_RESET = 1024;
    localparam int unsigned MARK_SAT    = 2047;

    bit                marks[mbla_pkg::POOL_CELLS];
    int unsigned       cell_count;
    int unsigned       sweep_ptr;
    int unsigned       marked_total;
    bit                after_mark;
    t_alloc_reply      replies_due[$];
    int unsigned       errors;
    int unsigned       n_mark, n_alloc, n_need_mark, n_full;
    int unsigned       peak_count;

    function new();
        foreach (marks[i]) marks[i] = 1'b0;
        cell_count   = COUNT_RESET;
        sweep_ptr    = 0;
        marked_total = 0;
        after_mark   = 1'b0;
        errors       = 0;
        n_mark       = 0;
        n_alloc      = 0;
        n_need_mark  = 0;
        n_full       = 0;
        peak_count   = 0;
    endfunction

    function int unsigned live_cells();
        return (cell_count < mbla_pkg::POOL_CELLS) ? cell_count : mbla_pkg::POOL_CELLS;
    endfunction

    function void set_cell_count(mbla_pkg::t_cnt value);
        cell_count = value;
    endfunction

    function void note_command(mbla_pkg::t_cmd cmd, mbla_pkg::t_cell id);
        int unsigned  n;
        int unsigned  c;
        int unsigned  thresh;
        bit           hit;
        t_alloc_reply r;
        n         = live_cells();
        r.cell_id = '0;
        if (cmd == mbla_pkg::CMD_MARK) begin
            if (id < n && !marks[id]) begin
                marks[id] = 1'b1;
                if (marked_total < MARK_SAT) marked_total++;
            end
            r.status = mbla_pkg::ST_MARKED;
        end else begin
            // lazy sweep: clear marks until the first free cell
            hit = 1'b0;
            c   = sweep_ptr;
            while (!hit && c < n) begin
                if (marks[c]) begin
                    marks[c] = 1'b0;
                    c++;
                end else begin
                    hit = 1'b1;
                end
            end
            if (hit) begin
                r.status   = mbla_pkg::ST_ALLOC;
                r.cell_id  = mbla_pkg::t_cell'(c);
                sweep_ptr  = c + 1;
                after_mark = 1'b0;
            end else if (!after_mark) begin
                r.status     = mbla_pkg::ST_NEED_MARK;
                marked_total = 0;
                sweep_ptr    = 0;
                after_mark   = 1'b1;
            end else begin
                r.status   = mbla_pkg::ST_FULL;
                after_mark = 1'b0;
            end
        end
        thresh      = (n < 4) ? 1 : n - n / 4;
        r.count     = mbla_pkg::t_cnt'(marked_total);
        r.hint      = (marked_total >= thresh);
        replies_due.push_back(r);
    endfunction

    function void check_reply(logic [1:0] status, mbla_pkg::t_cell cell_id,
                              mbla_pkg::t_cnt count, logic hint);
        t_alloc_reply exp;
        if (replies_due.size() == 0) begin
            $error("reply with nothing due: status %0d cell %0d count %0d",
                   status, cell_id, count);
            errors++;
            return;
        end
        exp = replies_due.pop_front();
        if (status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, status);
            errors++;
        end
        if (cell_id !== exp.cell_id) begin
            $error("cell_id: expected %0d, actual %0d", exp.cell_id, cell_id);
            errors++;
        end
        if (count !== exp.count) begin
            $error("marked_count: expected %0d, actual %0d", exp.count, count);
            errors++;
        end
        if (hint !== exp.hint) begin
            $error("grow_hint: expected %0d, actual %0d", exp.hint, hint);
            errors++;
        end
        case (exp.status)
            mbla_pkg::ST_ALLOC:     n_alloc++;
            mbla_pkg::ST_NEED_MARK: n_need_mark++;
            mbla_pkg::ST_FULL:      n_full++;
            default:                n_mark++;
        endcase
        if (exp.count > peak_count) peak_count = exp.count;
    endfunction
endclass

module tb_mark_bit_lazy_sweep_allocator_unit;

    // The guard sits well above a full run, even with every alloc sweeping
    // the whole pool under heavy stalls.
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned PLAN_LEN     = 15;

    // cell_count settings for the random phases; 0, 1, 1024, 2047 and 1025
    // are the edges (the last two clamp to the pool size)
    localparam mbla_pkg::t_cnt COUNT_PLAN [PLAN_LEN] = '{
        11'd1, 11'd0, 11'd2, 11'd3, 11'd4, 11'd5, 11'd7, 11'd12,
        11'd33, 11'd100, 11'd1023, 11'd2047, 11'd1025, 11'd6, 11'd1024
    };

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_THIRD,
        RX_SPARSE
    } t_rx_mode;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    logic            i_command;
    mbla_pkg::t_cell i_mark_id;
    logic            o_out_valid;
    logic            i_out_ready;
    logic  [1:0]     o_status;
    mbla_pkg::t_cell o_cell_id;
    mbla_pkg::t_cnt  o_marked_count;
    logic            o_grow_hint;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    mbla_pkg::t_cnt  i_cfg_data;

    alloc_scoreboard sb;

    int unsigned burst_left    = 0;
    int unsigned cycle_no      = 0;
    int unsigned hold_asks     = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned mode_left     = 0;
    int unsigned rx_phase      = 0;
    int unsigned settings_used = 0;
    t_rx_mode    rx_mode       = RX_FREE;

    mark_bit_lazy_sweep_allocator_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_mark_id      (i_mark_id),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_cell_id      (o_cell_id),
        .o_marked_count (o_marked_count),
        .o_grow_hint    (o_grow_hint),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Run guard: a hang or a lost reply ends here.
    always @(posedge i_clk) begin
        cycle_no++;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("tb_mark_bit_lazy_sweep_allocator_unit: errors");
            $finish;
        end
    end

    // Result side. Every transfer is checked against the oldest reply due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_reply(o_status, o_cell_id, o_marked_count, o_grow_hint);
    end

    // Result-side back-pressure. Stalls follow a mode that is redrawn at random
    // whenever its run ends (free running, coin toss, one in three, rare stalls). A
    // request from the stimulus raises a long hold-off, counted down here, so
    // the block fills and must refuse further input transfers.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left   = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_FREE:  i_out_ready <= 1'b1;
                RX_COIN:  i_out_ready <= 1'($urandom_range(0, 1));
                RX_THIRD: i_out_ready <= (rx_phase % 3 == 0);
                default:  i_out_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // One input transfer. The sender works in bursts: when a burst runs out
    // it may drop valid for a random gap before the next one. Returns in the
    // step of the transfer with valid still high, so the caller either
    // offers the next command at once or lowers valid.
    task automatic send_cmd(input mbla_pkg::t_cmd cmd, input mbla_pkg::t_cell id);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_mark_id  <= id;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(cmd, id);
    endtask

    // Stop offering and wait until every reply due has been seen.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write; only ever issued with the block idle.
    task automatic write_cell_count(input mbla_pkg::t_cnt value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_cell_count(value);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mixed marks and allocs. Once a mark phase has been asked for, marks
    // dominate so that the next alloc has live cells to sweep past. A few
    // marks use a full-width random id (mostly out of range at small counts).
    task automatic random_phase(input int unsigned items);
        int unsigned n;
        int unsigned r;
        int unsigned alloc_pct;
        n = sb.live_cells();
        repeat (items) begin
            alloc_pct = sb.after_mark ? 20 : 45;
            r         = $urandom_range(0, 99);
            if (r < alloc_pct)
                send_cmd(mbla_pkg::CMD_ALLOC, mbla_pkg::t_cell'($urandom));
            else if (r < 88 && n != 0)
                send_cmd(mbla_pkg::CMD_MARK, mbla_pkg::t_cell'($urandom_range(0, n - 1)));
            else
                send_cmd(mbla_pkg::CMD_MARK, mbla_pkg::t_cell'($urandom));
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_command   <= mbla_pkg::CMD_MARK;
        i_mark_id   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // reset count (1024): id extremes, a repeat mark, allocs past a mark
        send_cmd(mbla_pkg::CMD_MARK, mbla_pkg::t_cell'(0));
        send_cmd(mbla_pkg::CMD_MARK, mbla_pkg::t_cell'(mbla_pkg::POOL_CELLS - 1));
        send_cmd(mbla_pkg::CMD_MARK, mbla_pkg::t_cell'(0));
        send_cmd(mbla_pkg::CMD_ALLOC, mbla_pkg::t_cell'(0));
        send_cmd(mbla_pkg::CMD_ALLOC, '1);
        wait_idle();
        // four cells: out-of-range mark, grow hint, need mark, full, restart
        write_cell_count(mbla_pkg::t_cnt'(4));
        send_cmd(mbla_pkg::CMD_MARK, mbla_pkg::t_cell'(mbla_pkg::POOL_CELLS - 1));
        send_cmd(mbla_pkg::CMD_MARK, mbla_pkg::t_cell'(3));
        send_cmd(mbla_pkg::CMD_ALLOC, mbla_pkg::t_cell'(0));
        for (int c = 0; c < 4; c++) send_cmd(mbla_pkg::CMD_MARK, mbla_pkg::t_cell'(c));
        send_cmd(mbla_pkg::CMD_ALLOC, mbla_pkg::t_cell'(0));
        send_cmd(mbla_pkg::CMD_ALLOC, mbla_pkg::t_cell'(0));
        wait_idle();
        // move the sweep pointer to 6, then shrink the pool below it
        write_cell_count(mbla_pkg::t_cnt'(8));
        for (int c = 1; c < 5; c++) send_cmd(mbla_pkg::CMD_MARK, mbla_pkg::t_cell'(c));
        send_cmd(mbla_pkg::CMD_ALLOC, mbla_pkg::t_cell'(0));
        wait_idle();
        write_cell_count(mbla_pkg::t_cnt'(4));
        send_cmd(mbla_pkg::CMD_ALLOC, mbla_pkg::t_cell'(0));
        wait_idle();
        // empty pool: allocs can only fail, every mark is out of range
        write_cell_count(mbla_pkg::t_cnt'(0));
        send_cmd(mbla_pkg::CMD_ALLOC, mbla_pkg::t_cell'(0));
        send_cmd(mbla_pkg::CMD_ALLOC, mbla_pkg::t_cell'(0));
        send_cmd(mbla_pkg::CMD_MARK, mbla_pkg::t_cell'(0));

        // --- random, one phase per cell_count setting ---
        for (int i = 0; i < PLAN_LEN; i++) begin
            wait_idle();
            write_cell_count(COUNT_PLAN[i]);
            // long result hold-off while the sender keeps offering
            if (i == 3 || i == 10) hold_asks <= hold_asks + 1;
            random_phase($urandom_range(20, 32));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d replies: %0d marks, %0d allocs, %0d need-mark, %0d full",
                 sb.n_mark + sb.n_alloc + sb.n_need_mark + sb.n_full,
                 sb.n_mark, sb.n_alloc, sb.n_need_mark, sb.n_full);
        $display("%0d cell_count writes, %0d long output hold-offs, peak marked count %0d",
                 settings_used, hold_served, sb.peak_count);
        if (sb.errors == 0) begin
            $display("tb_mark_bit_lazy_sweep_allocator_unit: clean");
        end else begin
            $display("tb_mark_bit_lazy_sweep_allocator_unit: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== mark_bit_lazy_sweep_allocator_unit.f =====
sv/mbla_pkg.sv
sv/mbla_mark_store.sv
sv/mark_bit_lazy_sweep_allocator_unit.sv
sv/mbla_port_checker.sv
tb/tb_mark_bit_lazy_sweep_allocator_unit.sv
